### rtl/sfrr_pkg.sv
// Shared types and constants for the segmented frequency/recency replacement block.
// No dependencies.
`timescale 1ns / 1ps
package sfrr_pkg;
	localparam int NUM_SETS    = 2048;
	localparam int NUM_WAYS    = 16;
	localparam int HISTORY_LEN = 32;
	localparam logic [3:0] FREQ_TOP    = 4'd15;
	localparam logic [7:0] STAMP_RESET = 8'd255;

	localparam logic [1:0] KIND_INVALID = 2'd0;
	localparam logic [1:0] KIND_PHASE   = 2'd1;
	localparam logic [1:0] KIND_COLD    = 2'd2;
	localparam logic [1:0] KIND_HOT     = 2'd3;

	localparam logic [1:0] REG_HOT_CAP   = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_PROMOTE   = 2'd2;
	localparam logic [1:0] REG_DEMOTE    = 2'd3;

	typedef struct packed {
		logic [4:0] hot_capacity;
		logic [5:0] threshold;
		logic [3:0] promote_level;
		logic [3:0] demote_level;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;     // clearing pass write of current clear row
		logic rd;        // issue set read
		logic scan_init; // start way scan
		logic scan_step; // advance way scan
		logic wr;        // write back the updated set
		logic out_load;  // load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic scan_last;
		logic is_query;
		logic way_ok;
	} dp_stat_t;
endpackage

### rtl/sfrr_ctrl.sv
// Controller FSM for the replacement block: clearing pass, then per-request sequencing.
// Depends on sfrr_pkg.
`timescale 1ns / 1ps
module sfrr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_busy,
	input  sfrr_pkg::dp_stat_t stat,
	output logic               in_ready,
	output sfrr_pkg::dp_cmd_t  cmd
);
	import sfrr_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.rd = in_fire;
			end
			ST_READ: cmd.scan_init = 1'b1;
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_DONE: begin
				cmd.wr = !stat.is_query && stat.way_ok;
				cmd.out_load = stat.is_query && !out_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: if (stat.clear_done) state_q <= ST_IDLE;
				ST_IDLE: if (in_fire) state_q <= ST_READ;
				ST_READ: state_q <= ST_SCAN;
				ST_SCAN: if (stat.scan_last) state_q <= ST_DONE;
				ST_DONE: if (!stat.is_query || !out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !cmd.rd && !cmd.wr && !cmd.out_load)
		else $error("activity during clear");
	a_load_query: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.is_query && !cmd.wr)
		else $error("result load on update");
endmodule

### rtl/sfrr_datapath.sv
// Datapath: per-set memories, way scan unit, update logic and result register.
// Depends on sfrr_pkg.
`timescale 1ns / 1ps
module sfrr_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sfrr_pkg::dp_cmd_t  cmd,
	input  sfrr_pkg::cfg_t     cfg,
	input  logic               in_cmd,
	input  logic [10:0]        in_set,
	input  logic [3:0]         in_way,
	input  logic               in_hit,
	input  logic               out_taken,
	output logic               out_valid,
	output logic [3:0]         out_way,
	output logic [1:0]         out_kind,
	output sfrr_pkg::dp_stat_t stat
);
	import sfrr_pkg::*;

	localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WW = $clog2(NUM_WAYS);
	localparam int PW = $clog2(HISTORY_LEN);
	localparam int CW = $clog2(HISTORY_LEN + 1);
	localparam int LW = 14;
	localparam int RW = NUM_WAYS * LW + 8 + HISTORY_LEN + PW;

	// one row per set: ways {valid,hot,freq,stamp}, counter, history, pointer
	logic [RW-1:0] mem [NUM_SETS];
	logic [RW-1:0] row_q;
	logic [SW-1:0] clr_q, set_q;
	logic          cmd_q, hit_q, ok_q;
	logic [WW-1:0] way_q;

	logic [LW-1:0]          lines_q [NUM_WAYS];
	logic [7:0]             ctr_q;
	logic [HISTORY_LEN-1:0] hist_q;
	logic [PW-1:0]          ptr_q;

	logic [WW:0]   idx_q;
	logic          inv_found_q, hot_found_q, cold_found_q, hotf_found_q;
	logic [WW-1:0] inv_w_q, hot_w_q, cold_w_q, hotf_w_q;
	logic [7:0]    hot_s_q, cold_s_q, hotf_s_q;
	logic [3:0]    cold_f_q, hotf_f_q;
	logic [CW-1:0] hits_q;
	logic [WW:0]   nhot_q;

	logic [SW-1:0] set_red;
	logic [RW-1:0] reset_row, new_row;
	logic [LW-1:0] cur;

	always_comb begin
		set_red = SW'(32'(in_set) % NUM_SETS);
		reset_row = '0;
		for (int i = 0; i < NUM_WAYS; i++)
			reset_row[i*LW +: 8] = STAMP_RESET;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) mem[clr_q] <= reset_row;
		else if (cmd.wr) mem[set_q] <= new_row;
		if (cmd.rd) row_q <= mem[set_red];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear) clr_q <= clr_q + 1'b1;
	end
	assign stat.clear_done = (32'(clr_q) == NUM_SETS - 1);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			set_q <= set_red;
			cmd_q <= in_cmd;
			hit_q <= in_hit;
			way_q <= WW'(in_way);
			ok_q  <= (32'(in_way) < NUM_WAYS);
		end
	end

	assign cur = lines_q[idx_q[WW-1:0]];

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			for (int i = 0; i < NUM_WAYS; i++) lines_q[i] <= row_q[i*LW +: LW];
			ctr_q  <= row_q[NUM_WAYS*LW +: 8];
			hist_q <= row_q[NUM_WAYS*LW+8 +: HISTORY_LEN];
			ptr_q  <= row_q[NUM_WAYS*LW+8+HISTORY_LEN +: PW];
			idx_q <= '0;
			inv_found_q <= 1'b0; hot_found_q <= 1'b0;
			cold_found_q <= 1'b0; hotf_found_q <= 1'b0;
			hits_q <= '0; nhot_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			// history popcount rides on the way scan, several bits per step
			begin
				logic [CW-1:0] add;
				add = '0;
				for (int k = 0; k < 4; k++)
					if (32'(idx_q) * 4 + k < HISTORY_LEN)
						add = add + CW'(hist_q[(32'(idx_q) * 4 + k) % HISTORY_LEN]);
				hits_q <= hits_q + add;
			end
			if (32'(idx_q) < NUM_WAYS) begin
				if (cur[12]) nhot_q <= nhot_q + 1'b1;
				if (!cur[13] && !inv_found_q) begin
					inv_found_q <= 1'b1; inv_w_q <= idx_q[WW-1:0];
				end
				if (cur[12]) begin
					if (!hot_found_q || cur[7:0] < hot_s_q) begin
						hot_found_q <= 1'b1; hot_w_q <= idx_q[WW-1:0]; hot_s_q <= cur[7:0];
					end
					if (!hotf_found_q || cur[11:8] < hotf_f_q ||
						(cur[11:8] == hotf_f_q && cur[7:0] < hotf_s_q)) begin
						hotf_found_q <= 1'b1; hotf_w_q <= idx_q[WW-1:0];
						hotf_f_q <= cur[11:8]; hotf_s_q <= cur[7:0];
					end
				end else begin
					if (!cold_found_q || cur[11:8] < cold_f_q ||
						(cur[11:8] == cold_f_q && cur[7:0] < cold_s_q)) begin
						cold_found_q <= 1'b1; cold_w_q <= idx_q[WW-1:0];
						cold_f_q <= cur[11:8]; cold_s_q <= cur[7:0];
					end
				end
			end
		end
	end

	localparam int STEPS = (NUM_WAYS > (HISTORY_LEN + 3) / 4) ? NUM_WAYS : (HISTORY_LEN + 3) / 4;
	assign stat.scan_last = (32'(idx_q) == STEPS - 1);
	assign stat.is_query = !cmd_q;
	assign stat.way_ok = ok_q;

	// update of the addressed way
	always_comb begin
		logic [LW-1:0] ln;
		logic [7:0] nctr;
		logic [3:0] f;
		logic hot;
		new_row = '0;
		for (int i = 0; i < NUM_WAYS; i++) new_row[i*LW +: LW] = lines_q[i];
		ln = lines_q[way_q];
		nctr = ctr_q + 8'd1;
		f = ln[11:8];
		if (hit_q) begin
			if (f < FREQ_TOP) f = f + 4'd1;
		end else if (f != 4'd0) f = f - 4'd1;
		hot = ln[12];
		if (!hot && f >= cfg.promote_level) begin
			if (6'(nhot_q) < 6'(cfg.hot_capacity)) hot = 1'b1;
		end else if (hot && f < cfg.demote_level) hot = 1'b0;
		new_row[32'(way_q)*LW +: LW] = {1'b1, hot, f, nctr};
		new_row[NUM_WAYS*LW +: 8] = nctr;
		new_row[NUM_WAYS*LW+8 +: HISTORY_LEN] = hist_q;
		new_row[NUM_WAYS*LW+8+32'(ptr_q)] = hit_q;
		new_row[NUM_WAYS*LW+8+HISTORY_LEN +: PW] =
			PW'((32'(ptr_q) + 1) % HISTORY_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_taken) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (inv_found_q) begin
				out_way <= 4'(inv_w_q); out_kind <= KIND_INVALID;
			end else if (7'(hits_q) < 7'(cfg.threshold) && hot_found_q) begin
				out_way <= 4'(hot_w_q); out_kind <= KIND_PHASE;
			end else if (cold_found_q) begin
				out_way <= 4'(cold_w_q); out_kind <= KIND_COLD;
			end else if (hotf_found_q) begin
				out_way <= 4'(hotf_w_q); out_kind <= KIND_HOT;
			end else begin
				out_way <= 4'd0; out_kind <= KIND_HOT;
			end
		end
	end

	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear && cmd.rd))
		else $error("read during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_taken |=> out_valid)
		else $error("result dropped");
	a_nhot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> 32'(nhot_q) <= NUM_WAYS)
		else $error("hot count overflow");
endmodule

### rtl/segmented_freq_recency_replacement_top.sv
// Top level of the segmented frequency/recency replacement block.
// Depends on sfrr_pkg, sfrr_ctrl, sfrr_datapath.
`timescale 1ns / 1ps
// channel   dir  handshake                fields
// s_axis    in   s_tvalid/s_tready        tuser: cmd, was_hit; tdata: set_index, way_index
// m_axis    out  m_tvalid/m_tready        tdata: victim_way; tuser: victim_kind
// apb       in   psel/penable/pwrite      regs 0..3 at 4*i
//
// Each request runs as one set-row read, a way-serial scan of the row, then write-back
// or result load.
// After reset a clearing pass writes every set row while s_tready stays low;
// APB writes are taken throughout.
// A query waits in the final step while a prior result is still unclaimed.
module segmented_freq_recency_replacement_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [10:0] set_index, [14:11] way_index
	input  logic [1:0]  s_tuser,   // [0] cmd, [1] was_hit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] victim_way
	output logic [1:0]  m_tuser,   // [1:0] victim_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sfrr_pkg::*;

	cfg_t cfg_q;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic in_fire;
	logic [3:0] vway;
	logic [1:0] vkind;

	assign pready = 1'b1;
	assign in_fire = s_tvalid && s_tready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{hot_capacity: 5'd6, threshold: 6'd8,
				promote_level: 4'd7, demote_level: 4'd3};
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_HOT_CAP:   cfg_q.hot_capacity  <= pwdata[4:0];
				REG_THRESHOLD: cfg_q.threshold     <= pwdata[5:0];
				REG_PROMOTE:   cfg_q.promote_level <= pwdata[3:0];
				REG_DEMOTE:    cfg_q.demote_level  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_HOT_CAP:   prdata[4:0] = cfg_q.hot_capacity;
			REG_THRESHOLD: prdata[5:0] = cfg_q.threshold;
			REG_PROMOTE:   prdata[3:0] = cfg_q.promote_level;
			REG_DEMOTE:    prdata[3:0] = cfg_q.demote_level;
			default: ;
		endcase
	end

	sfrr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(m_tvalid && !m_tready), .stat(stat),
		.in_ready(s_tready), .cmd(cmd)
	);

	sfrr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg_q),
		.in_cmd(s_tuser[0]), .in_set(s_tdata[10:0]), .in_way(s_tdata[14:11]),
		.in_hit(s_tuser[1]), .out_taken(m_tready), .out_valid(m_tvalid),
		.out_way(vway), .out_kind(vkind), .stat(stat)
	);

	assign m_tdata = {4'b0000, vway};
	assign m_tuser = vkind;
endmodule
